@@ hdl/ptrs_pkg.sv @@
// Shared types and codes for the periodic task release scheduler.
`default_nettype none

package ptrs_pkg;

    localparam int PeriodW = 32;
    localparam int StepW   = 16;
    localparam int TaskIdxW = 3;

    // Input function codes.
    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_TICK     = 1'b1;

    // Result kind codes.
    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_TICK     = 1'b1;

    // Register answer status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OCCUPIED = 2'd1;
    localparam logic [1:0] STAT_ZERO     = 2'd2;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_TICK_STEP  = 1'b0;
    localparam logic REG_TIME_LIMIT = 1'b1;

    localparam logic [StepW-1:0]   TICK_STEP_RST  = 16'd1;
    localparam logic [PeriodW-1:0] TIME_LIMIT_RST = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_HIT,
        ST_FLUSH
    } ptrs_state_t;

    // Status returned by the bit-serial remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } ptrs_div_res_t;

endpackage

`default_nettype wire

@@ hdl/ptrs_serial_mod.sv @@
// Bit-serial remainder unit: one dividend bit per cycle, restoring style.
`default_nettype none

module ptrs_serial_mod
    import ptrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [PeriodW-1:0] dividend,
    input  wire logic [PeriodW-1:0] divisor,
    output ptrs_div_res_t           res
);

    localparam int CntW = $clog2(PeriodW + 1);

    logic [PeriodW-1:0] shift_reg, shift_next;
    logic [PeriodW-1:0] rem_reg, rem_next;
    logic [PeriodW-1:0] divisor_reg, divisor_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [PeriodW:0]   cand;
    logic [PeriodW:0]   diff;

    always_comb
    begin
        cand         = {rem_reg, shift_reg[PeriodW-1]};
        diff         = cand - {1'b0, divisor_reg};
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        if (start)
        begin
            shift_next   = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            cnt_next     = CntW'(PeriodW);
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[PeriodW-2:0], 1'b0};
            // The candidate stays below twice the divisor, so one subtract suffices.
            if (cand >= {1'b0, divisor_reg})
                rem_next = diff[PeriodW-1:0];
            else
                rem_next = cand[PeriodW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign res.done = done_reg;
    assign res.zero = (rem_reg == '0);

endmodule

`default_nettype wire

@@ hdl/ptrs_slot_table.sv @@
// Task slot table: valid bits in flip-flops and a period memory with registered read.
`default_nettype none

module ptrs_slot_table
    import ptrs_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int AW    = 3
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [PeriodW-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic      [PeriodW-1:0] rd_data,
    output logic      [SLOTS-1:0]   used
);

    logic [PeriodW-1:0] period_mem_reg [SLOTS];
    logic [PeriodW-1:0] rd_data_reg;
    logic [SLOTS-1:0]   used_reg, used_next;

    always_comb
    begin
        used_next = used_reg;
        if (wr_en)
            used_next[wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            period_mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= period_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign used    = used_reg;

endmodule

`default_nettype wire

@@ hdl/periodic_task_release_scheduler.sv @@
// Top level of the periodic task release scheduler: control sequencer and ports.
//
//  Channel  Direction  Handshake                   Beat contents
//  in       input      in_valid / in_ready         func, slot, period
//  out      output     out_valid / out_ready       kind, status, fired, task_index, last
//  cfg      input      APB psel/penable/pwrite     tick_step (0x0), time_limit (0x4)
//
// A register beat's answer waits in ST_REG until the result register is free and is then
// loaded into the result register, so it shows after the state register and that register.
// A tick scans up to eight slots: an empty slot is passed over in ST_READ, an occupied one goes
// through a table read, the divider load, 32 remainder steps and a done step, and handing on a
// held release ahead of a later one adds a pass through ST_HIT.
// Reset clears the slot valid bits and elapsed time and sets the config registers to their reset values at once.
// A stalled output holds the scan only when a beat is to be handed on, until that beat is taken.
`default_nettype none

module periodic_task_release_scheduler
    import ptrs_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic [2:0]         slot,
    input  wire logic [31:0]        period,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    kind,
    output logic      [1:0]         status,
    output logic                    fired,
    output logic      [2:0]         task_index,
    output logic                    last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NSCAN = (SLOTS < 8) ? SLOTS : 8;
    localparam int CW    = $clog2(NSCAN + 1);

    ptrs_state_t state_reg, state_next;

    logic [StepW-1:0]    tick_step_reg, tick_step_next;
    logic [PeriodW-1:0]  time_limit_reg, time_limit_next;
    logic [PeriodW-1:0]  elapsed_reg, elapsed_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TaskIdxW-1:0] pend_idx_reg, pend_idx_next;
    logic [1:0]          res_status_reg, res_status_next;

    logic                out_valid_reg, out_valid_next;
    logic                kind_reg, kind_next;
    logic [1:0]          status_reg, status_next;
    logic                fired_reg, fired_next;
    logic [TaskIdxW-1:0] task_index_reg, task_index_next;
    logic                last_reg, last_next;

    logic                in_acc;
    logic                cfg_wr;
    logic                can_load;
    logic                in_range;
    logic                occupied;
    logic                scan_end;
    logic                cur_used;
    logic [PeriodW:0]    sum;

    logic                tbl_wr;
    logic                tbl_rd;
    logic [PeriodW-1:0]  rd_data;
    logic [SLOTS-1:0]    used;
    logic                div_start;
    ptrs_div_res_t       div_res;

    assign in_acc   = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign can_load = !out_valid_reg || out_ready;
    assign in_range = ({29'd0, slot} < SLOTS);
    assign occupied = in_range && used[AW'(slot)];
    assign scan_end = (idx_reg == CW'(NSCAN));
    assign cur_used = !scan_end && used[AW'(idx_reg)];
    assign sum      = {1'b0, elapsed_reg} + {{(PeriodW - StepW + 1){1'b0}}, tick_step_reg};

    ptrs_slot_table #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr),
        .wr_addr (AW'(slot)),
        .wr_data (period),
        .rd_en   (tbl_rd),
        .rd_addr (AW'(idx_reg)),
        .rd_data (rd_data),
        .used    (used)
    );

    ptrs_serial_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg),
        .divisor  (rd_data),
        .res      (div_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = (func == FUNC_TICK) ? ST_READ : ST_REG;
            ST_REG:
                if (can_load)
                    state_next = ST_IDLE;
            ST_READ:
                if (scan_end)
                    state_next = ST_FLUSH;
                else if (cur_used)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_DIV;
            ST_DIV:
                if (div_res.done)
                begin
                    if (div_res.zero && pend_valid_reg)
                        state_next = ST_HIT;
                    else
                        state_next = ST_READ;
                end
            ST_HIT:
                if (can_load)
                    state_next = ST_READ;
            ST_FLUSH:
                if (can_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        tbl_wr          = 1'b0;
        tbl_rd          = 1'b0;
        div_start       = 1'b0;
        elapsed_next    = elapsed_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        status_next     = status_reg;
        fired_next      = fired_reg;
        task_index_next = task_index_reg;
        last_next       = last_reg;

        tick_step_next  = tick_step_reg;
        time_limit_next = time_limit_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_TICK_STEP:  tick_step_next  = pwdata[StepW-1:0];
                REG_TIME_LIMIT: time_limit_next = pwdata;
                default:        tick_step_next  = tick_step_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (func == FUNC_TICK)
                    begin
                        if (sum > {1'b0, time_limit_reg})
                            elapsed_next = {{(PeriodW - StepW){1'b0}}, tick_step_reg};
                        else
                            elapsed_next = sum[PeriodW-1:0];
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                    end
                    else if (!in_range || occupied)
                        res_status_next = STAT_OCCUPIED;
                    else if (period == '0)
                        res_status_next = STAT_ZERO;
                    else
                    begin
                        res_status_next = STAT_OK;
                        tbl_wr          = 1'b1;
                    end
                end
            ST_REG:
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_REGISTER;
                    status_next     = res_status_reg;
                    fired_next      = 1'b0;
                    task_index_next = '0;
                    last_next       = 1'b1;
                end
            ST_READ:
                if (cur_used)
                    tbl_rd = 1'b1;
                else if (!scan_end)
                    idx_next = idx_reg + 1'b1;
            ST_LOAD:
                div_start = 1'b1;
            ST_DIV:
                if (div_res.done)
                begin
                    if (!div_res.zero)
                        idx_next = idx_reg + 1'b1;
                    else if (!pend_valid_reg)
                    begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = TaskIdxW'(idx_reg);
                        idx_next        = idx_reg + 1'b1;
                    end
                end
            ST_HIT:
                // A later release is known, so the held one is not the final beat.
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_TICK;
                    status_next     = STAT_OK;
                    fired_next      = 1'b1;
                    task_index_next = pend_idx_reg;
                    last_next       = 1'b0;
                    pend_idx_next   = TaskIdxW'(idx_reg);
                    idx_next        = idx_reg + 1'b1;
                end
            ST_FLUSH:
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_TICK;
                    status_next     = STAT_OK;
                    fired_next      = pend_valid_reg;
                    task_index_next = pend_valid_reg ? pend_idx_reg : '0;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_step_reg  <= TICK_STEP_RST;
            time_limit_reg <= TIME_LIMIT_RST;
            elapsed_reg    <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_step_reg  <= tick_step_next;
            time_limit_reg <= time_limit_next;
            elapsed_reg    <= elapsed_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        kind_reg       <= kind_next;
        status_reg     <= status_next;
        fired_reg      <= fired_next;
        task_index_reg <= task_index_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        case (paddr[2])
            REG_TICK_STEP:  prdata = {{(32 - StepW){1'b0}}, tick_step_reg};
            REG_TIME_LIMIT: prdata = time_limit_reg;
            default:        prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign status     = status_reg;
    assign fired      = fired_reg;
    assign task_index = task_index_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ hdl/ptrs_checker.sv @@
// Port-level checks for the periodic task release scheduler, bound to the top level.
`default_nettype none

module ptrs_checker
    import ptrs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        func,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        kind,
    input wire logic [1:0]  status,
    input wire logic        fired,
    input wire logic [2:0]  task_index,
    input wire logic        last
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({kind, status, fired, task_index, last}))
        else $error("result beat changed while stalled");

    // A register answer is a single beat with nothing released.
    a_reg_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_REGISTER |-> last && !fired && task_index == 3'd0)
        else $error("register answer malformed");

    // A tick report that releases nothing ends the tick and names slot zero.
    a_tick_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TICK && !fired |-> last && task_index == 3'd0
            && status == STAT_OK)
        else $error("empty tick report malformed");

    // A register beat taken while the output is free shows its answer after passing ST_REG and the result register.
    a_reg_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_REGISTER && (!out_valid || out_ready)
            |-> ##2 out_valid && kind == KIND_REGISTER)
        else $error("register answer late");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STAT_OK || status == STAT_OCCUPIED || status == STAT_ZERO)
        else $error("status out of range");

endmodule

bind periodic_task_release_scheduler ptrs_checker u_ptrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .status     (status),
    .fired      (fired),
    .task_index (task_index),
    .last       (last)
);

`default_nettype wire

@@ verif/ptrs_release_checker.sv @@
// Checker for the periodic task release scheduler: watches all ports, predicts, compares.
`default_nettype none

module ptrs_release_checker
    import ptrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               func,
    input  wire logic [2:0]         slot,
    input  wire logic [31:0]        period,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic               kind,
    input  wire logic [1:0]         status,
    input  wire logic               fired,
    input  wire logic [2:0]         task_index,
    input  wire logic               last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic [31:0]        prdata,
    input  wire logic               pready,
    output int                      errors,
    output int                      pending,
    output int                      beats_in,
    output int                      ticks,
    output int                      releases,
    output int                      wraps
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic       fired;
        logic [2:0] task_index;
        logic       last;
    } release_beat_t;

    release_beat_t        due_q[$];
    logic [StepW-1:0]     step_ms;
    logic [PeriodW-1:0]   limit_ms;
    logic [PeriodW-1:0]   now_ms;
    logic [7:0]           taken;
    logic [PeriodW-1:0]   cycle_ms[8];

    // Works out the answer or the release list for one accepted input beat.
    task automatic predict_item(input logic f, input logic [2:0] s,
                                input logic [PeriodW-1:0] p);
        release_beat_t b;
        int hits;
        b = '0;
        hits = 0;
        if (f == FUNC_REGISTER) begin
            b.kind = KIND_REGISTER;
            b.last = 1'b1;
            if (taken[s]) begin
                b.status = STAT_OCCUPIED;
            end
            else if (p == '0) begin
                b.status = STAT_ZERO;
            end
            else begin
                taken[s] = 1'b1;
                cycle_ms[s] = p;
                b.status = STAT_OK;
            end
            due_q.push_back(b);
        end
        else begin
            ticks++;
            // The wrap test is done on 33 bits so that it cannot overflow.
            if ({1'b0, now_ms} + {17'b0, step_ms} > {1'b0, limit_ms}) begin
                now_ms = {16'b0, step_ms};
                wraps++;
            end
            else begin
                now_ms = now_ms + {16'b0, step_ms};
            end
            b.kind = KIND_TICK;
            for (int i = 0; i < 8; i++) begin
                if (taken[i] && (now_ms % cycle_ms[i]) == '0) begin
                    b.fired = 1'b1;
                    b.task_index = 3'(i);
                    due_q.push_back(b);
                    hits++;
                end
            end
            if (hits == 0) begin
                b.last = 1'b1;
                due_q.push_back(b);
            end
            else begin
                b = due_q.pop_back();
                b.last = 1'b1;
                due_q.push_back(b);
            end
            releases += hits;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        release_beat_t got;
        release_beat_t want;
        logic [31:0] reg_val;
        if (!rst_n) begin
            due_q.delete();
            step_ms = TICK_STEP_RST;
            limit_ms = TIME_LIMIT_RST;
            now_ms = '0;
            taken = '0;
            for (int i = 0; i < 8; i++) begin
                cycle_ms[i] = '0;
            end
            pending = 0;
        end
        else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_TICK_STEP) begin
                        step_ms = pwdata[StepW-1:0];
                    end
                    else begin
                        limit_ms = pwdata;
                    end
                end
                else begin
                    reg_val = (paddr[2] == REG_TICK_STEP) ? {16'b0, step_ms} : limit_ms;
                    if (prdata !== reg_val) begin
                        errors++;
                        $display("%0t: register read at 0x%0h expected 0x%08h got 0x%08h",
                                 $time, paddr, reg_val, prdata);
                    end
                end
            end
            if (out_valid && out_ready) begin
                got = {kind, status, fired, task_index, last};
                if (due_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected: kind=%0d status=%0d",
                             $time, got.kind, got.status,
                             " fired=%0d task_index=%0d last=%0d",
                             got.fired, got.task_index, got.last);
                end
                else begin
                    want = due_q.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.fired !== want.fired || got.task_index !== want.task_index ||
                        got.last !== want.last) begin
                        errors++;
                        $display("%0t: result mismatch expected kind=%0d status=%0d fired=%0d",
                                 $time, want.kind, want.status, want.fired,
                                 " task_index=%0d last=%0d, got kind=%0d status=%0d",
                                 want.task_index, want.last, got.kind, got.status,
                                 " fired=%0d task_index=%0d last=%0d",
                                 got.fired, got.task_index, got.last);
                    end
                end
            end
            if (in_valid && in_ready) begin
                beats_in++;
                predict_item(func, slot, period);
            end
            pending = due_q.size();
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_periodic_task_release_scheduler.sv @@
// Testbench top for the periodic task release scheduler: stimulus, config writes, verdict.
`default_nettype none

module tb_periodic_task_release_scheduler
    import ptrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    wire logic   in_ready;
    logic        func;
    logic [2:0]  slot;
    logic [31:0] period;
    wire logic   out_valid;
    logic        out_ready;
    wire logic   kind;
    wire logic [1:0] status;
    wire logic   fired;
    wire logic [2:0] task_index;
    wire logic   last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire logic [31:0] prdata;
    wire logic   pready;

    int errors;
    int pending;
    int beats_in;
    int ticks;
    int releases;
    int wraps;

    bit sender_idles;
    bit sink_stalls;

    periodic_task_release_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .slot(slot), .period(period),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .status(status), .fired(fired), .task_index(task_index), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ptrs_release_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .slot(slot), .period(period),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .status(status), .fired(fired), .task_index(task_index), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending), .beats_in(beats_in),
        .ticks(ticks), .releases(releases), .wraps(wraps)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("tb_periodic_task_release_scheduler: errors");
        $finish;
    end

    // Result sink: stalls come in short random bursts while enabled.
    initial begin : result_sink
        int n;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // Presents one beat and returns once it has been taken.
    task automatic send_beat(input logic f, input logic [2:0] s, input logic [31:0] p);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        func = f;
        slot = s;
        period = p;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_tick();
        send_beat(FUNC_TICK, 3'($urandom_range(0, 7)), $urandom);
    endtask

    task automatic send_register(input logic [2:0] s, input logic [31:0] p);
        send_beat(FUNC_REGISTER, s, p);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Registers change only with nothing in flight; each write is read back.
    task automatic set_timing(input logic [15:0] step, input logic [31:0] limit);
        drain();
        apb_access(1'b1, REG_TICK_STEP, {16'b0, step});
        apb_access(1'b1, REG_TIME_LIMIT, limit);
        apb_access(1'b0, REG_TICK_STEP, '0);
        apb_access(1'b0, REG_TIME_LIMIT, '0);
    endtask

    task automatic run_random(input int n);
        logic [31:0] p;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
            if ($urandom_range(0, 99) < 30) begin
                case ($urandom_range(0, 4))
                    0: p = '0;
                    1: p = $urandom;
                    2: p = 32'd1 << $urandom_range(0, 31);
                    default: p = $urandom_range(1, 12);
                endcase
                send_register(3'($urandom_range(0, 7)), p);
            end
            else begin
                send_tick();
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_REGISTER;
        slot = '0;
        period = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sender_idles = 1'b1;
        sink_stalls = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, zero period, occupied before zero, extreme period.
        send_tick();
        send_register(3'd3, 32'd0);
        send_register(3'd3, 32'd3);
        send_register(3'd3, 32'd0);
        send_register(3'd3, 32'hFFFF_FFFF);
        send_register(3'd0, 32'd2);
        send_register(3'd7, 32'hFFFF_FFFF);
        repeat (5) send_tick();
        // A zero step holds the time; with the limit passed it restarts at zero.
        set_timing(16'd0, 32'hFFFF_FFFF);
        send_tick();
        set_timing(16'd0, 32'd5);
        send_tick();
        set_timing(16'hFFFF, 32'hFFFF_FFFF);
        repeat (2) send_tick();
        // Lands exactly on the limit, then wraps on the next tick.
        set_timing(16'd3, 32'd131073);
        repeat (2) send_tick();
        set_timing(16'd1, 32'd1);
        repeat (2) send_tick();

        set_timing(16'd1, 32'hFFFF_FFFF);
        run_random(90);
        set_timing(16'($urandom_range(2, 7)), $urandom_range(20, 200));
        run_random(90);
        set_timing(16'($urandom_range(0, 65535)), $urandom);
        run_random(90);
        set_timing(16'hFFFF, 32'hFFFF_FFFF);
        run_random(90);
        // Final stretch runs at full rate on both sides.
        sender_idles = 1'b0;
        sink_stalls = 1'b0;
        set_timing(16'd1, 32'd360);
        run_random(90);

        drain();
        repeat (20) @(posedge clk);
        $display("Run covered %0d input beats: %0d ticks with %0d task releases, %0d time wraps,",
                 beats_in, ticks, releases, wraps);
        $display("tick steps from 0 to 65535 and time limits from 1 to 2^32-1.");
        if (errors == 0 && pending == 0) begin
            $display("tb_periodic_task_release_scheduler: clean");
        end
        else begin
            $display("tb_periodic_task_release_scheduler: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/ptrs_pkg.sv
hdl/ptrs_serial_mod.sv
hdl/ptrs_slot_table.sv
hdl/periodic_task_release_scheduler.sv
hdl/ptrs_checker.sv
verif/ptrs_release_checker.sv
verif/tb_periodic_task_release_scheduler.sv
